### rtl/mrc_pkg.sv
package mrc_pkg;

   // Field widths
   localparam int OPCODE_W = 2;
   localparam int CRC_W    = 32;
   localparam int ID_W     = 6;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 3;
   localparam int LEVEL_W  = 6;
   localparam int MODE_W   = 7;

   // Defaults for the top-level parameters
   localparam int NUM_ENTRIES_DEF = 32;
   localparam int STORE_BYTES_DEF = 8;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REPORT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

   // Entry mode encoding: bit 6 queued, bits 5..0 free / fail count / perm / good
   localparam logic [LEVEL_W-1:0] MODE_FREE   = 6'h00;
   localparam logic [LEVEL_W-1:0] MODE_FAIL1  = 6'h01;
   localparam logic [LEVEL_W-1:0] MODE_FAIL2  = 6'h3D;
   localparam logic [LEVEL_W-1:0] MODE_FAILN  = 6'h3E;
   localparam logic [LEVEL_W-1:0] MODE_GOOD   = 6'h3F;
   localparam logic [MODE_W-1:0]  MODE_QUEUED = 7'h40;

   localparam logic [LEVEL_W-1:0] MAX_FAIL_RESET = 6'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_GOOD   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PERM   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BADID  = 3'd5;

   // Mask of the stored bytes
   function automatic logic [DATA_W-1:0] store_mask(input int bytes);
      logic [DATA_W-1:0] m;
      if (bytes >= 8) begin
         m = '1;
      end else if (bytes <= 0) begin
         m = '0;
      end else begin
         m = (DATA_W'(1) << (8 * bytes)) - DATA_W'(1);
      end
      return m;
   endfunction

endpackage

### rtl/mrc_req_if.sv
interface mrc_req_if;
   logic                         valid;
   logic                         ready;
   logic [mrc_pkg::OPCODE_W-1:0] opcode;
   logic [mrc_pkg::CRC_W-1:0]    msg_crc;
   logic [mrc_pkg::ID_W-1:0]     entry_id;
   logic                         result_good;
   logic [mrc_pkg::DATA_W-1:0]   store_data;

   modport source(output valid, opcode, msg_crc, entry_id, result_good, store_data,
                  input ready);
   modport sink(input valid, opcode, msg_crc, entry_id, result_good, store_data,
                output ready);
endinterface

### rtl/mrc_rsp_if.sv
interface mrc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mrc_pkg::STATUS_W-1:0] status;
   logic [mrc_pkg::ID_W-1:0]     queue_id;
   logic [mrc_pkg::DATA_W-1:0]   stored_data;
   logic [mrc_pkg::LEVEL_W-1:0]  fail_level;

   modport source(output valid, status, queue_id, stored_data, fail_level,
                  input ready);
   modport sink(input valid, status, queue_id, stored_data, fail_level,
                output ready);
endinterface

### rtl/mrc_ram.sv
module mrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/message_result_cache.sv
// Message result cache: a ring of NUM_ENTRIES message CRCs, each with an outcome state.
// A lookup (opcode 0) walks backward from the insertion pointer, one entry per clock
// through a single registered read port and one CRC comparator, and stops at the first
// free entry, a match, or after a full lap. A hit answers good (with the stored data),
// queued (a failed entry not yet permanent is requeued), permanently failed, or busy when
// the entry is already queued. A miss installs the CRC at the pointer as queued, returns
// its 1-based id and advances the pointer; if that slot is still queued the answer is busy.
// A report (opcode 1) marks an entry good and keeps the low STORE_BYTES bytes of data, or
// bumps its fail count (a good entry restarts at one) up to max_fail. A clear (opcode 2)
// frees every entry at once. Timing: one transfer in at a time; a lookup passes S_SRCH once
// per entry examined (1 to NUM_ENTRIES), bounded by the sequential walk through the entry
// RAMs, then S_MISS on a miss, then S_RESP. A report passes S_RPT and S_RESP, a clear or a
// bad request S_RESP alone. The result sits in an output register, so the next request is
// taken while it waits. The user must write the max_fail register (csr_wr_en / csr_wr_data)
// only while the block is idle, which it does not enforce; values above 62 are held at 62.
module message_result_cache #(
   parameter int NUM_ENTRIES = mrc_pkg::NUM_ENTRIES_DEF,
   parameter int STORE_BYTES = mrc_pkg::STORE_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   mrc_req_if.sink                     req_ch,
   mrc_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [mrc_pkg::LEVEL_W-1:0] csr_wr_data
);

   localparam int IW = $clog2(NUM_ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);
   localparam logic [mrc_pkg::DATA_W-1:0] STORE_MASK = mrc_pkg::store_mask(STORE_BYTES);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRCH = 3'd1;  // walk the ring, one entry per clock
   localparam logic [2:0] S_MISS = 3'd2;  // check the pointer slot, install
   localparam logic [2:0] S_RPT  = 3'd3;  // update the reported entry
   localparam logic [2:0] S_RESP = 3'd4;  // hand result to the output register

   logic [2:0]             state_ff, state_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic [NUM_ENTRIES-1:0] valid_ff, valid_in;
   logic                   vld_rd_ff;
   logic [mrc_pkg::LEVEL_W-1:0] max_fail_ff, max_fail_in;

   // Captured request
   logic [mrc_pkg::CRC_W-1:0]  crc_ff, crc_in;
   logic                       good_ff, good_in;
   logic [mrc_pkg::DATA_W-1:0] data_ff, data_in;

   // Pending result
   logic [mrc_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [mrc_pkg::ID_W-1:0]     res_qid_ff, res_qid_in;
   logic [mrc_pkg::DATA_W-1:0]   res_sdata_ff, res_sdata_in;
   logic [mrc_pkg::LEVEL_W-1:0]  res_level_ff, res_level_in;

   // Output register
   logic                         out_valid_ff, out_valid_in;
   logic [mrc_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [mrc_pkg::ID_W-1:0]     out_qid_ff, out_qid_in;
   logic [mrc_pkg::DATA_W-1:0]   out_sdata_ff, out_sdata_in;
   logic [mrc_pkg::LEVEL_W-1:0]  out_level_ff, out_level_in;

   // Entry RAM ports
   logic                        ram_we_crc, ram_we_mode, ram_we_store;
   logic [mrc_pkg::MODE_W-1:0]  mode_wd;
   logic [mrc_pkg::CRC_W-1:0]   crc_rd;
   logic [mrc_pkg::MODE_W-1:0]  mode_rd;
   logic [mrc_pkg::DATA_W-1:0]  store_rd;

   // Derived values
   logic [mrc_pkg::MODE_W-1:0]  mode_eff;
   logic [mrc_pkg::LEVEL_W-1:0] mode_lo;
   logic [mrc_pkg::LEVEL_W-1:0] fail_base;
   logic [mrc_pkg::LEVEL_W-1:0] fail_next;
   logic [mrc_pkg::ID_W-1:0]    qid_idx;
   logic                        accept;
   logic                        id_ok;
   logic [IW-1:0]               idx_dec;
   logic [IW-1:0]               ptr_inc;

   mrc_ram #(.WIDTH(mrc_pkg::CRC_W), .DEPTH(NUM_ENTRIES)) u_crc_ram (
      .clock   (clock),
      .wr_en   (ram_we_crc),
      .wr_addr (idx_ff),
      .wr_data (crc_ff),
      .rd_addr (idx_in),
      .rd_data (crc_rd)
   );

   mrc_ram #(.WIDTH(mrc_pkg::MODE_W), .DEPTH(NUM_ENTRIES)) u_mode_ram (
      .clock   (clock),
      .wr_en   (ram_we_mode),
      .wr_addr (idx_ff),
      .wr_data (mode_wd),
      .rd_addr (idx_in),
      .rd_data (mode_rd)
   );

   mrc_ram #(.WIDTH(mrc_pkg::DATA_W), .DEPTH(NUM_ENTRIES)) u_store_ram (
      .clock   (clock),
      .wr_en   (ram_we_store),
      .wr_addr (idx_ff),
      .wr_data (data_ff & STORE_MASK),
      .rd_addr (idx_in),
      .rd_data (store_rd)
   );

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);

   // A slot with a clear valid bit reads as free
   assign mode_eff = vld_rd_ff ? mode_rd : '0;
   assign mode_lo  = mode_eff[mrc_pkg::LEVEL_W-1:0];

   // Failed report: good restarts from free, count saturates at permanent
   assign fail_base = (mode_lo == mrc_pkg::MODE_GOOD) ? mrc_pkg::MODE_FREE : mode_lo;
   always_comb begin
      fail_next = fail_base + mrc_pkg::LEVEL_W'(1);
      if (fail_next >= max_fail_ff) begin
         fail_next = mrc_pkg::MODE_FAILN;
      end
   end

   assign qid_idx = mrc_pkg::ID_W'(32'(idx_ff) + 32'd1);
   assign id_ok   = (req_ch.entry_id != '0) && (32'(req_ch.entry_id) <= NUM_ENTRIES);
   assign idx_dec = (idx_ff == '0) ? LAST_IDX : idx_ff - IW'(1);
   assign ptr_inc = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + IW'(1);

   always_comb begin
      max_fail_in = max_fail_ff;
      if (csr_wr_en) begin
         max_fail_in = (csr_wr_data > mrc_pkg::MODE_FAILN) ? mrc_pkg::MODE_FAILN
                                                           : csr_wr_data;
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      valid_in      = valid_ff;
      crc_in        = crc_ff;
      good_in       = good_ff;
      data_in       = data_ff;
      res_status_in = res_status_ff;
      res_qid_in    = res_qid_ff;
      res_sdata_in  = res_sdata_ff;
      res_level_in  = res_level_ff;
      ram_we_crc    = 1'b0;
      ram_we_mode   = 1'b0;
      ram_we_store  = 1'b0;
      mode_wd       = mode_eff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               crc_in        = req_ch.msg_crc;
               good_in       = req_ch.result_good;
               data_in       = req_ch.store_data;
               res_status_in = mrc_pkg::ST_BADID;
               res_qid_in    = '0;
               res_sdata_in  = '0;
               res_level_in  = '0;
               case (req_ch.opcode)
                  mrc_pkg::OP_LOOKUP: begin
                     idx_in   = (ptr_ff == '0) ? LAST_IDX : ptr_ff - IW'(1);
                     state_in = S_SRCH;
                  end
                  mrc_pkg::OP_REPORT: begin
                     if (id_ok) begin
                        idx_in   = IW'(32'(req_ch.entry_id) - 32'd1);
                        state_in = S_RPT;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  mrc_pkg::OP_CLEAR: begin
                     valid_in      = '0;
                     ptr_in        = '0;
                     res_status_in = mrc_pkg::ST_DONE;
                     state_in      = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_SRCH: begin
            if (mode_eff == '0) begin
               idx_in   = ptr_ff;
               state_in = S_MISS;
            end else if (crc_rd == crc_ff) begin
               state_in = S_RESP;
               if ((mode_eff & mrc_pkg::MODE_QUEUED) != '0) begin
                  res_status_in = mrc_pkg::ST_BUSY;
               end else if (mode_lo == mrc_pkg::MODE_GOOD) begin
                  res_status_in = mrc_pkg::ST_GOOD;
                  res_sdata_in  = store_rd & STORE_MASK;
               end else if (mode_lo inside {[mrc_pkg::MODE_FAIL1 : mrc_pkg::MODE_FAIL2]}) begin
                  mode_wd       = mode_eff | mrc_pkg::MODE_QUEUED;
                  ram_we_mode   = 1'b1;
                  res_status_in = mrc_pkg::ST_QUEUED;
                  res_qid_in    = qid_idx;
               end else begin
                  res_status_in = mrc_pkg::ST_PERM;
               end
            end else if (idx_ff == ptr_ff) begin
               // full lap without a match
               idx_in   = ptr_ff;
               state_in = S_MISS;
            end else begin
               idx_in = idx_dec;
            end
         end

         S_MISS: begin
            state_in = S_RESP;
            if ((mode_eff & mrc_pkg::MODE_QUEUED) != '0) begin
               res_status_in = mrc_pkg::ST_BUSY;
            end else begin
               ram_we_crc       = 1'b1;
               ram_we_mode      = 1'b1;
               mode_wd          = mrc_pkg::MODE_QUEUED;
               valid_in[idx_ff] = 1'b1;
               res_status_in    = mrc_pkg::ST_QUEUED;
               res_qid_in       = qid_idx;
               ptr_in           = ptr_inc;
            end
         end

         S_RPT: begin
            state_in      = S_RESP;
            res_status_in = mrc_pkg::ST_DONE;
            if (good_ff) begin
               ram_we_store     = 1'b1;
               ram_we_mode      = 1'b1;
               mode_wd          = {1'b0, mrc_pkg::MODE_GOOD};
               valid_in[idx_ff] = 1'b1;
               res_level_in     = mrc_pkg::MODE_GOOD;
            end else if (fail_base <= mrc_pkg::MODE_FAIL2) begin
               ram_we_mode      = 1'b1;
               mode_wd          = {1'b0, fail_next};
               valid_in[idx_ff] = 1'b1;
               res_level_in     = fail_next;
            end else begin
               // permanently failed: left as it is
               res_level_in = mode_lo;
            end
         end

         S_RESP: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_status_in = out_status_ff;
      out_qid_in    = out_qid_ff;
      out_sdata_in  = out_sdata_ff;
      out_level_in  = out_level_ff;
      if (state_ff == S_RESP && (!out_valid_ff || rsp_ch.ready)) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_qid_in    = res_qid_ff;
         out_sdata_in  = res_sdata_ff;
         out_level_in  = res_level_ff;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_status_ff;
   assign rsp_ch.queue_id    = out_qid_ff;
   assign rsp_ch.stored_data = out_sdata_ff;
   assign rsp_ch.fail_level  = out_level_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         max_fail_ff  <= mrc_pkg::MAX_FAIL_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         valid_ff     <= valid_in;
         max_fail_ff  <= max_fail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      vld_rd_ff     <= valid_ff[idx_in];
      crc_ff        <= crc_in;
      good_ff       <= good_in;
      data_ff       <= data_in;
      res_status_ff <= res_status_in;
      res_qid_ff    <= res_qid_in;
      res_sdata_ff  <= res_sdata_in;
      res_level_ff  <= res_level_in;
      out_status_ff <= out_status_in;
      out_qid_ff    <= out_qid_in;
      out_sdata_ff  <= out_sdata_in;
      out_level_ff  <= out_level_in;
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

package mrc_tb_pkg;
   import mrc_pkg::*;

   localparam int ENTRIES    = NUM_ENTRIES_DEF;
   localparam int KEPT_BYTES = STORE_BYTES_DEF;

   // opcode with no function, answered with bad id
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [CRC_W-1:0]    msg_crc;
      logic [ID_W-1:0]     entry_id;
      logic                result_good;
      logic [DATA_W-1:0]   store_data;
   } cache_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     queue_id;
      logic [DATA_W-1:0]   stored_data;
      logic [LEVEL_W-1:0]  fail_level;
   } cache_response_type;

   // Shadow of the cache plus the queue of responses still owed by the block.
   class cache_ledger_type;
      logic [CRC_W-1:0]  tag [ENTRIES];
      logic [MODE_W-1:0] mode [ENTRIES];
      logic [DATA_W-1:0] kept [ENTRIES];
      bit                tag_loaded [ENTRIES];
      int unsigned       wr_ptr;
      logic [LEVEL_W-1:0] fail_limit;
      logic [DATA_W-1:0] keep_mask;
      cache_response_type owed_rsp [$];
      int                mismatches;

      function new();
         keep_mask = '0;
         for (int b = 0; b < KEPT_BYTES && b < 8; b++) keep_mask[b*8 +: 8] = 8'hFF;
         foreach (mode[i]) begin
            mode[i]       = '0;
            tag_loaded[i] = 1'b0;
         end
         wr_ptr     = 0;
         fail_limit = MAX_FAIL_RESET;
         mismatches = 0;
      endfunction

      function void set_fail_limit(logic [LEVEL_W-1:0] v);
         fail_limit = (v > MODE_FAILN) ? MODE_FAILN : v;
      endfunction

      // backward walk from the pointer; stops at a free slot, a match, or after a full lap
      function int search_ring(logic [CRC_W-1:0] crc);
         int i;
         i = wr_ptr;
         repeat (ENTRIES) begin
            i = (i == 0) ? ENTRIES - 1 : i - 1;
            if (mode[i] == '0) return -1;
            if (tag[i] == crc) return i;
         end
         return -1;
      endfunction

      function cache_response_type predict_response(cache_request_type r);
         cache_response_type rsp;
         int                hit;
         int                k;
         logic [MODE_W-1:0] m;
         logic [LEVEL_W-1:0] lvl;
         logic [LEVEL_W-1:0] nxt;
         rsp = '0;
         rsp.status = ST_BADID;
         case (r.opcode)
            OP_LOOKUP: begin
               hit = search_ring(r.msg_crc);
               if (hit >= 0) begin
                  m = mode[hit];
                  if ((m & MODE_QUEUED) != '0) begin
                     rsp.status = ST_BUSY;
                  end else if (m[LEVEL_W-1:0] == MODE_GOOD) begin
                     rsp.status      = ST_GOOD;
                     rsp.stored_data = kept[hit] & keep_mask;
                  end else if (m[LEVEL_W-1:0] inside {[MODE_FAIL1 : MODE_FAIL2]}) begin
                     mode[hit]    = m | MODE_QUEUED;
                     rsp.status   = ST_QUEUED;
                     rsp.queue_id = ID_W'(hit + 1);
                  end else begin
                     rsp.status = ST_PERM;
                  end
               end else if ((mode[wr_ptr] & MODE_QUEUED) != '0) begin
                  rsp.status = ST_BUSY;
               end else begin
                  tag[wr_ptr]        = r.msg_crc;
                  tag_loaded[wr_ptr] = 1'b1;
                  mode[wr_ptr]       = MODE_QUEUED;
                  rsp.status         = ST_QUEUED;
                  rsp.queue_id       = ID_W'(wr_ptr + 1);
                  wr_ptr             = (wr_ptr + 1 >= ENTRIES) ? 0 : wr_ptr + 1;
               end
            end
            OP_REPORT: begin
               if (r.entry_id >= 1 && r.entry_id <= ENTRIES) begin
                  k = r.entry_id - 1;
                  rsp.status = ST_DONE;
                  if (r.result_good) begin
                     kept[k] = r.store_data & keep_mask;
                     mode[k] = {1'b0, MODE_GOOD};
                  end else begin
                     lvl = mode[k][LEVEL_W-1:0];
                     if (lvl == MODE_GOOD) begin
                        mode[k] = '0;
                        lvl     = MODE_FREE;
                     end
                     // permanent entries keep their mode, queued flag included
                     if (lvl <= MODE_FAIL2) begin
                        nxt = lvl + 1'b1;
                        if (nxt >= fail_limit) nxt = MODE_FAILN;
                        mode[k] = {1'b0, nxt};
                     end
                  end
                  rsp.fail_level = mode[k][LEVEL_W-1:0];
               end
            end
            OP_CLEAR: begin
               foreach (mode[i]) mode[i] = '0;
               wr_ptr     = 0;
               rsp.status = ST_DONE;
            end
            default: ;
         endcase
         return rsp;
      endfunction

      function void note_request(cache_request_type r);
         owed_rsp.push_back(predict_response(r));
      endfunction

      function int owed_count();
         return owed_rsp.size();
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] mismatch %0d: %s", $realtime, mismatches, what);
      endtask

      task check_response(cache_response_type got);
         cache_response_type want;
         if (owed_rsp.size() == 0) begin
            report_mismatch($sformatf("response with none owed, status %0d", got.status));
            return;
         end
         want = owed_rsp.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.queue_id !== want.queue_id)
            report_mismatch($sformatf("queue_id %0d, want %0d", got.queue_id, want.queue_id));
         if (got.stored_data !== want.stored_data)
            report_mismatch($sformatf("stored_data %h, want %h",
                                      got.stored_data, want.stored_data));
         if (got.fail_level !== want.fail_level)
            report_mismatch($sformatf("fail_level %0d, want %0d",
                                      got.fail_level, want.fail_level));
      endtask

      // 1-based ids currently waiting for a report
      function int unsigned pick_queued_id();
         int unsigned ids [$];
         foreach (mode[i]) if (mode[i][MODE_W-1]) ids.push_back(i + 1);
         if (ids.size() == 0) return 0;
         return ids[$urandom_range(0, ids.size() - 1)];
      endfunction

      // any id whose CRC slot has been written; others must never be reported
      function int unsigned pick_loaded_id();
         int unsigned ids [$];
         foreach (tag_loaded[i]) if (tag_loaded[i]) ids.push_back(i + 1);
         if (ids.size() == 0) return 0;
         return ids[$urandom_range(0, ids.size() - 1)];
      endfunction
   endclass

endpackage

module testbench;
   import mrc_pkg::*;
   import mrc_tb_pkg::*;

   localparam int CLK_HALF         = 2;
   localparam int RESET_CYCLES     = 4;
   localparam int NUM_PHASES       = 6;
   localparam int ITEMS_PER_PHASE  = 60;
   localparam int POOL_SIZE        = 20;
   // longest lookup is a full lap plus install
   localparam int SETTLE_CYCLES    = ENTRIES + 8;
   localparam int LONG_HOLD_CYCLES = 300;
   // ~500 transfers at the worst-case lookup time plus the longest idle gap per side,
   // plus the long hold and drains, taken several times over
   localparam int CYCLE_LIMIT      = 500_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_wr_en;
   logic [LEVEL_W-1:0]  csr_wr_data;

   mrc_req_if req_ch ();
   mrc_rsp_if rsp_ch ();

   cache_ledger_type board = new();

   logic [CRC_W-1:0] crc_pool [POOL_SIZE];
   bit               hold_rsp_pending = 1'b0;
   int unsigned      cycle_count = 0;

   message_result_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("message_result_cache verification failed");
         $finish;
      end
   end

   // Mostly short idle gaps, now and then a long one.
   function automatic int idle_gap();
      int unsigned dice;
      dice = $urandom_range(0, 99);
      if (dice < 40) return 0;
      if (dice < 85) return $urandom_range(1, 3);
      if (dice < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Response side: ready runs of random length with idle gaps between them.
   // When asked, ready drops for a long stretch so the output register and
   // the request stage both fill and the block stops taking transfers.
   initial begin : rsp_pacing
      int run_len;
      int gap;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp_pending) begin
            hold_rsp_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         run_len = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 12);
         rsp_ch.ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         gap = idle_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Response monitor; values read right after the edge are the pre-edge ones.
   always @(posedge clock) begin
      cache_response_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.status      = rsp_ch.status;
         got.queue_id    = rsp_ch.queue_id;
         got.stored_data = rsp_ch.stored_data;
         got.fail_level  = rsp_ch.fail_level;
         board.check_response(got);
      end
   end

   // Offer one request and hold it until the transfer; valid stays high on
   // return so back-to-back requests need no extra edge.
   task automatic send_request(input cache_request_type r);
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= r.opcode;
      req_ch.msg_crc     <= r.msg_crc;
      req_ch.entry_id    <= r.entry_id;
      req_ch.result_good <= r.result_good;
      req_ch.store_data  <= r.store_data;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Sender stops and waits out every owed response, then the block's
   // worst-case busy time, so the block is idle afterwards.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (board.owed_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_fail(input logic [LEVEL_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_fail_limit(v);
   endtask

   function automatic cache_request_type make_request(input logic [OPCODE_W-1:0] op,
                                                      input logic [CRC_W-1:0] crc,
                                                      input logic [ID_W-1:0] id,
                                                      input logic good,
                                                      input logic [DATA_W-1:0] data);
      cache_request_type r;
      r.opcode      = op;
      r.msg_crc     = crc;
      r.entry_id    = id;
      r.result_good = good;
      r.store_data  = data;
      return r;
   endfunction

   function automatic logic [ID_W-1:0] bad_id();
      return ($urandom_range(0, 1) == 0) ? ID_W'(0) : ID_W'($urandom_range(ENTRIES + 1, 63));
   endfunction

   // Random traffic: lookups mostly hit a small CRC pool so entries cycle
   // through queued / failed / good; reports mostly answer queued ids.
   // Reports only name ids whose CRC slot was written, or out-of-range ids.
   function automatic cache_request_type random_request();
      cache_request_type r;
      int unsigned    dice;
      int unsigned    id;
      r = make_request(OP_LOOKUP, $urandom, ID_W'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1)), {$urandom, $urandom});
      dice = $urandom_range(0, 99);
      if (dice < 55) begin
         if ($urandom_range(0, 4) != 0) r.msg_crc = crc_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (dice < 92) begin
         r.opcode = OP_REPORT;
         id = board.pick_queued_id();
         if (id == 0 || $urandom_range(0, 4) == 0) id = board.pick_loaded_id();
         r.entry_id = (id == 0 || $urandom_range(0, 11) == 0) ? bad_id() : ID_W'(id);
      end else if (dice < 94) begin
         r.opcode = OP_CLEAR;
      end else if (dice < 96) begin
         r.opcode = OP_UNUSED;
      end
      return r;
   endfunction

   // More fresh lookups than entries: fills the ring, forces full-lap
   // searches and busy answers when the pointer slot is still queued.
   task automatic flood_ring();
      cache_request_type r;
      repeat (ENTRIES + 2) begin
         r = random_request();
         r.opcode  = OP_LOOKUP;
         r.msg_crc = $urandom;
         pause_sender(($urandom_range(0, 3) == 0) ? idle_gap() : 0);
         send_request(r);
      end
   endtask

   // Hand-picked walk through every outcome, at the reset max_fail of 2.
   task automatic run_directed();
      cache_request_type plan [$];
      logic [DATA_W-1:0] ones;
      ones = '1;
      plan.push_back(make_request(OP_LOOKUP, 32'h0, 6'd0, 1'b0, '0));        // miss, id 1
      plan.push_back(make_request(OP_LOOKUP, 32'h0, 6'd0, 1'b0, '0));        // hit on queued
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd1, 1'b0, '0));        // fail count 1
      plan.push_back(make_request(OP_LOOKUP, 32'h0, 6'd0, 1'b0, '0));        // requeue
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd1, 1'b0, '0));        // reaches limit
      plan.push_back(make_request(OP_LOOKUP, 32'h0, 6'd0, 1'b0, '0));        // permanent
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd1, 1'b0, '0));        // stays permanent
      plan.push_back(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0, '0)); // miss, id 2
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd2, 1'b1, ones));
      plan.push_back(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0, '0)); // good hit
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd2, 1'b0, ones));      // good restarts
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd2, 1'b1, '0));
      plan.push_back(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0, '0));
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd0, 1'b1, ones));      // id zero
      plan.push_back(make_request(OP_REPORT, 32'hFFFF_FFFF, 6'd63, 1'b1, ones));
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd33, 1'b0, '0));
      plan.push_back(make_request(OP_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b1, ones));
      plan.push_back(make_request(OP_LOOKUP, 32'hA5A5_5A5A, 6'd0, 1'b0, '0)); // id 3
      plan.push_back(make_request(OP_LOOKUP, 32'h0000_1234, 6'd0, 1'b0, '0)); // id 4
      plan.push_back(make_request(OP_CLEAR, 32'h0, 6'd0, 1'b0, '0));
      plan.push_back(make_request(OP_LOOKUP, 32'h0000_1234, 6'd0, 1'b0, '0)); // miss after clear
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd3, 1'b0, '0));        // free slot fails
      plan.push_back(make_request(OP_REPORT, 32'h0, 6'd1, 1'b1, 64'h0123_4567_89AB_CDEF));
      plan.push_back(make_request(OP_LOOKUP, 32'h0000_1234, 6'd0, 1'b0, '0));
      plan.push_back(make_request(OP_LOOKUP, 32'hA5A5_5A5A, 6'd0, 1'b0, '0));
      foreach (plan[i]) begin
         pause_sender(idle_gap());
         send_request(plan[i]);
      end
   endtask

   // max_fail per phase: reset value first, then the extremes, the
   // clamped value above 62, a random one, and back to 2.
   function automatic logic [LEVEL_W-1:0] limit_for_phase(input int phase);
      case (phase)
         1:       return 6'd1;
         2:       return 6'd62;
         3:       return 6'd63;
         4:       return LEVEL_W'($urandom_range(3, 10));
         default: return 6'd2;
      endcase
   endfunction

   initial begin : stimulus
      bit steady;
      int flood_at;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_LOOKUP;
      req_ch.msg_crc     = '0;
      req_ch.entry_id    = '0;
      req_ch.result_good = 1'b0;
      req_ch.store_data  = '0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      crc_pool[0] = 32'h0;
      crc_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) crc_pool[i] = $urandom;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            drain_block();
            write_max_fail(limit_for_phase(phase));
         end
         if (phase == 0) run_directed();
         // the sender keeps offering through this hold
         if (phase == 2) hold_rsp_pending = 1'b1;
         flood_at = (phase == 1 || phase == 4) ? $urandom_range(10, ITEMS_PER_PHASE - 10) : -1;
         steady   = 1'b0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 20 == 0) steady = ($urandom_range(0, 3) == 0);
            if (n == flood_at) flood_ring();
            pause_sender(steady ? 0 : idle_gap());
            send_request(random_request());
         end
      end

      drain_block();
      if (board.mismatches == 0) begin
         $display("message_result_cache verification clean");
      end else begin
         $display("message_result_cache verification failed");
      end
      $finish;
   end

endmodule
